FILE: hw/rtl/rnp_pkg.sv
// Shared types and constants for the RTP NAL fragment packetizer.
`timescale 1ns / 1ps
package rnp_pkg;

  // Width of NAL length and byte counters.
  localparam int LenBits = 16;

  // RTP fixed header length in bytes.
  localparam int RtpHdrLen = 12;

  // Configuration port address width: five 32-bit registers.
  localparam int PaddrBits = 5;

  // Default packet limit: Ethernet MTU less IP/UDP, plus RTP header and FU-A prefix.
  localparam int MtuBytes    = 1500;
  localparam int IpUdpBytes  = 28;
  localparam int MaxLenReset = MtuBytes - IpUdpBytes + RtpHdrLen + 2;
  localparam int PtReset     = 96;

  // RTP and fragmentation unit bit patterns.
  localparam logic [7:0] RtpVersionByte = 8'h80;
  localparam logic [7:0] H264NriMask    = 8'hE0;
  localparam logic [7:0] H264FuaType    = 8'h1C;
  localparam logic [7:0] H264TypeMask   = 8'h1F;
  localparam logic [7:0] H265KeepMask   = 8'h81;
  localparam logic [7:0] H265FuType     = 8'h62;
  localparam logic [7:0] H265TypeMask   = 8'h7E;
  localparam logic [7:0] FuStartBit     = 8'h80;
  localparam logic [7:0] FuEndBit       = 8'h40;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    RegCodecMode   = 3'd0,
    RegPayloadType = 3'd1,
    RegSourceId    = 3'd2,
    RegFirstSeq    = 3'd3,
    RegMaxLen      = 3'd4
  } reg_idx_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic        codec_mode;
    logic [6:0]  payload_type;
    logic [31:0] source_id;
    logic [15:0] first_sequence;
    logic [15:0] max_packet_len;
  } cfg_t;

  // One burst of output bytes caused by one input byte.
  typedef struct packed {
    logic        hdr;       // burst opens with a 12-byte RTP header
    logic        marker;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  pre0;      // FU indicator and header bytes
    logic [7:0]  pre1;
    logic [7:0]  pre2;
    logic [7:0]  data;
    logic        data_end;  // data byte closes its packet
    logic [3:0]  last_idx;  // index of the data byte in the burst
    logic [7:0]  chan;
  } desc_t;

endpackage

FILE: hw/rtl/rnp_in_if.sv
// Input channel: NAL bytes with valid/ready handshake.
`timescale 1ns / 1ps
interface rnp_in_if;
  import rnp_pkg::*;

  logic               valid;
  logic               ready;
  logic [7:0]         in_byte;
  logic               nal_first;
  logic [LenBits-1:0] nal_length;
  logic [31:0]        time_stamp;
  logic [7:0]         channel_tag;

  modport source (
    output valid, in_byte, nal_first, nal_length, time_stamp, channel_tag,
    input  ready
  );

  modport sink (
    input  valid, in_byte, nal_first, nal_length, time_stamp, channel_tag,
    output ready
  );
endinterface

FILE: hw/rtl/rnp_out_if.sv
// Output channel: RTP packet bytes with valid/ready handshake.
`timescale 1ns / 1ps
interface rnp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_start;
  logic       packet_end;
  logic       run_last;
  logic [7:0] out_channel;

  modport source (
    output valid, out_byte, packet_start, packet_end, run_last, out_channel,
    input  ready
  );

  modport sink (
    input  valid, out_byte, packet_start, packet_end, run_last, out_channel,
    output ready
  );
endinterface

FILE: hw/rtl/rnp_step.sv
// Input register, packetizer state and the per-byte step logic.
`timescale 1ns / 1ps
module rnp_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rnp_pkg::cfg_t cfg_i,
  input  logic          seq_load_i,
  rnp_in_if.sink        in_i,
  output rnp_pkg::desc_t desc_o,
  output logic          desc_valid_o,
  input  logic          desc_ready_i
);
  import rnp_pkg::*;

  // Input register.
  logic               a_valid_q;
  logic [7:0]         a_byte_q;
  logic               a_first_q;
  logic [LenBits-1:0] a_len_q;
  logic [31:0]        a_ts_q;
  logic [7:0]         a_chan_q;

  // Packetizer state.
  logic [15:0]        seq_q, seq_d;
  logic [31:0]        stamp_q, stamp_d;
  logic [LenBits-1:0] left_q, left_d;
  logic [15:0]        fill_q, fill_d;
  logic               frag_q, frag_d;
  logic [15:0]        ind_q, ind_d;
  logic [7:0]         fu_q, fu_d;
  logic               firstfr_q, firstfr_d;
  logic               due_q, due_d;

  // Step combinational signals.
  logic               has_res;
  logic               adv;
  logic [1:0]         prefix_len;
  logic [1:0]         nal_hdr_len;
  logic [4:0]         ovh;
  logic [15:0]        fs;
  logic [LenBits-1:0] len_eff;
  logic               fits;
  logic [LenBits-1:0] left_dec;
  logic [15:0]        fill_inc;
  logic               last_fr;
  desc_t              desc;

  // Fragment payload size and fit test.
  always_comb begin
    prefix_len  = cfg_i.codec_mode ? 2'd3 : 2'd2;
    nal_hdr_len = cfg_i.codec_mode ? 2'd2 : 2'd1;
    ovh         = 5'(RtpHdrLen) + 5'(prefix_len);
    if (cfg_i.max_packet_len <= 16'(ovh)) begin
      fs = 16'd1;
    end else begin
      fs = cfg_i.max_packet_len - 16'(ovh);
    end
    len_eff  = (a_len_q == '0) ? LenBits'(1) : a_len_q;
    fits     = ((17'(len_eff) + 17'(ovh)) <= 17'(cfg_i.max_packet_len)) ||
               (len_eff <= LenBits'(nal_hdr_len));
    left_dec = left_q - LenBits'(1);
    fill_inc = fill_q + 16'd1;
    last_fr  = 32'(left_q) <= 32'(fs);
  end

  // Next state and output burst for the byte in the input register.
  always_comb begin
    stamp_d   = stamp_q;
    left_d    = left_q;
    fill_d    = fill_q;
    frag_d    = frag_q;
    ind_d     = ind_q;
    fu_d      = fu_q;
    firstfr_d = firstfr_q;
    due_d     = due_q;
    has_res   = 1'b0;

    desc          = '0;
    desc.seq      = seq_q;
    desc.stamp    = stamp_q;
    desc.data     = a_byte_q;
    desc.chan     = a_chan_q;

    priority if (a_first_q) begin
      stamp_d   = a_ts_q;
      fill_d    = '0;
      firstfr_d = 1'b1;
      due_d     = 1'b0;
      left_d    = len_eff - LenBits'(1);
      if (fits) begin
        // Whole NAL in one packet.
        frag_d        = 1'b0;
        has_res       = 1'b1;
        desc.hdr      = 1'b1;
        desc.marker   = 1'b1;
        desc.stamp    = a_ts_q;
        desc.data_end = (len_eff == LenBits'(1));
        desc.last_idx = 4'(RtpHdrLen);
      end else begin
        // Start fragmenting: take the NAL header apart.
        frag_d = 1'b1;
        if (cfg_i.codec_mode) begin
          ind_d = {(a_byte_q & H265KeepMask) | H265FuType, 8'h00};
          fu_d  = (a_byte_q & H265TypeMask) >> 1;
          due_d = 1'b1;
        end else begin
          ind_d = {8'h00, (a_byte_q & H264NriMask) | H264FuaType};
          fu_d  = a_byte_q & H264TypeMask;
        end
      end
    end else if (left_q == '0) begin
      // Stray byte outside any NAL.
    end else if (!frag_q) begin
      left_d        = left_dec;
      has_res       = 1'b1;
      desc.data_end = (left_dec == '0);
    end else if (due_q) begin
      // Second H.265 NAL header byte.
      ind_d  = {ind_q[15:8], a_byte_q};
      due_d  = 1'b0;
      left_d = left_dec;
      if (left_dec == '0) begin
        frag_d = 1'b0;
      end
    end else begin
      has_res = 1'b1;
      if (fill_q == '0) begin
        // First payload byte of a fragment: header and FU prefix go first.
        desc.hdr    = 1'b1;
        desc.marker = last_fr;
        firstfr_d   = 1'b0;
        if (cfg_i.codec_mode) begin
          desc.pre0     = ind_q[15:8];
          desc.pre1     = ind_q[7:0];
          desc.pre2     = fu_q | (firstfr_q ? FuStartBit : 8'h00) |
                          (last_fr ? FuEndBit : 8'h00);
          desc.last_idx = 4'(RtpHdrLen + 3);
        end else begin
          desc.pre0     = ind_q[7:0];
          desc.pre1     = fu_q | (firstfr_q ? FuStartBit : 8'h00) |
                          (last_fr ? FuEndBit : 8'h00);
          desc.last_idx = 4'(RtpHdrLen + 2);
        end
      end
      left_d = left_dec;
      if (left_dec == '0 || fill_inc >= fs) begin
        desc.data_end = 1'b1;
        fill_d        = '0;
        if (left_dec == '0) begin
          frag_d = 1'b0;
        end
      end else begin
        fill_d = fill_inc;
      end
    end
  end

  // Handshake: bytes without output leave the input register at once.
  assign adv          = a_valid_q && (!has_res || desc_ready_i);
  assign in_i.ready   = !a_valid_q || adv;
  assign desc_valid_o = a_valid_q && has_res;
  assign desc_o       = desc;

  // Sequence number: loaded by a register write, bumped once per header.
  always_comb begin
    seq_d = seq_q;
    if (seq_load_i) begin
      seq_d = cfg_i.first_sequence;
    end else if (adv && desc.hdr) begin
      seq_d = seq_q + 16'd1;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_byte_q  <= in_i.in_byte;
      a_first_q <= in_i.nal_first;
      a_len_q   <= in_i.nal_length;
      a_ts_q    <= in_i.time_stamp;
      a_chan_q  <= in_i.channel_tag;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= '0;
      stamp_q   <= '0;
      left_q    <= '0;
      fill_q    <= '0;
      frag_q    <= 1'b0;
      ind_q     <= '0;
      fu_q      <= '0;
      firstfr_q <= 1'b1;
      due_q     <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (adv) begin
        stamp_q   <= stamp_d;
        left_q    <= left_d;
        fill_q    <= fill_d;
        frag_q    <= frag_d;
        ind_q     <= ind_d;
        fu_q      <= fu_d;
        firstfr_q <= firstfr_d;
        due_q     <= due_d;
      end
    end
  end

endmodule

FILE: hw/rtl/rnp_emit.sv
// Burst and output registers: one packet byte per cycle if not stalled.
`timescale 1ns / 1ps
module rnp_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rnp_pkg::cfg_t  cfg_i,
  input  rnp_pkg::desc_t desc_i,
  input  logic           desc_valid_i,
  output logic           desc_ready_o,
  rnp_out_if.source      out_o
);
  import rnp_pkg::*;

  // Burst register.
  logic       b_valid_q;
  desc_t      b_desc_q;
  logic [3:0] idx_q;

  // Output register.
  logic       c_valid_q;
  logic [7:0] c_byte_q;
  logic       c_start_q;
  logic       c_end_q;
  logic       c_last_q;
  logic [7:0] c_chan_q;

  logic       c_load;
  logic       b_move;
  logic       b_last;
  logic       b_take;
  logic [7:0] sel_byte;
  logic [7:0] hdr_byte;
  logic [7:0] pre_byte;

  assign c_load       = !c_valid_q || out_o.ready;
  assign b_move       = b_valid_q && c_load;
  assign b_last       = (idx_q == b_desc_q.last_idx);
  assign b_take       = !b_valid_q || (b_move && b_last);
  assign desc_ready_o = b_take;

  // RTP header byte at the current index.
  always_comb begin
    unique case (idx_q)
      4'd0:    hdr_byte = RtpVersionByte;
      4'd1:    hdr_byte = {b_desc_q.marker, cfg_i.payload_type};
      4'd2:    hdr_byte = b_desc_q.seq[15:8];
      4'd3:    hdr_byte = b_desc_q.seq[7:0];
      4'd4:    hdr_byte = b_desc_q.stamp[31:24];
      4'd5:    hdr_byte = b_desc_q.stamp[23:16];
      4'd6:    hdr_byte = b_desc_q.stamp[15:8];
      4'd7:    hdr_byte = b_desc_q.stamp[7:0];
      4'd8:    hdr_byte = cfg_i.source_id[31:24];
      4'd9:    hdr_byte = cfg_i.source_id[23:16];
      4'd10:   hdr_byte = cfg_i.source_id[15:8];
      4'd11:   hdr_byte = cfg_i.source_id[7:0];
      default: hdr_byte = '0;
    endcase
  end

  // FU prefix byte: indexes 12 to 14 map to prefix slots 0 to 2.
  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    pre_byte = b_desc_q.pre0;
      2'd1:    pre_byte = b_desc_q.pre1;
      2'd2:    pre_byte = b_desc_q.pre2;
      default: pre_byte = '0;
    endcase
  end

  // Data byte always closes the burst.
  always_comb begin
    priority if (b_last) begin
      sel_byte = b_desc_q.data;
    end else if (idx_q < 4'(RtpHdrLen)) begin
      sel_byte = hdr_byte;
    end else begin
      sel_byte = pre_byte;
    end
  end

  // Burst register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      idx_q     <= '0;
    end else if (b_take) begin
      b_valid_q <= desc_valid_i;
      idx_q     <= '0;
    end else if (b_move) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  // Burst payload.
  always_ff @(posedge clk_i) begin
    if (b_take && desc_valid_i) begin
      b_desc_q <= desc_i;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_load) begin
      c_valid_q <= b_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (b_move) begin
      c_byte_q  <= sel_byte;
      c_start_q <= b_desc_q.hdr && (idx_q == '0);
      c_end_q   <= b_last && b_desc_q.data_end;
      c_last_q  <= b_last;
      c_chan_q  <= b_desc_q.chan;
    end
  end

  assign out_o.valid        = c_valid_q;
  assign out_o.out_byte     = c_byte_q;
  assign out_o.packet_start = c_start_q;
  assign out_o.packet_end   = c_end_q;
  assign out_o.run_last     = c_last_q;
  assign out_o.out_channel  = c_chan_q;

endmodule

FILE: hw/rtl/rtp_nal_fragment_packetizer.sv
// Top level of the RTP packetizer for H.264 FU-A and H.265 FU fragmentation.
`timescale 1ns / 1ps
// Takes one NAL byte per request and emits RTP packet bytes, one per cycle
// while the output is ready. A NAL byte that continues a packet yields one
// output byte and the input takes a new byte every cycle unless stalled. A
// byte that opens a packet yields 13 to 16 output bytes (12-byte RTP header,
// FU indicator and FU header) and holds the input until the burst register
// has sent them all. NAL header bytes of a fragmented NAL are absorbed with
// no output. Bytes pass the input, burst and output registers. The user must
// write registers over the APB port only while idle; the block does not
// enforce it. Writing first_sequence also reloads the running sequence number.
module rtp_nal_fragment_packetizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rnp_in_if.sink                        in_i,
  rnp_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rnp_pkg::PaddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rnp_pkg::*;

  logic        mode_q;
  logic [6:0]  pt_q;
  logic [31:0] ssrc_q;
  logic [15:0] fseq_q;
  logic [15:0] maxlen_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        seq_load;
  cfg_t        cfg;
  desc_t       desc;
  logic        desc_valid;
  logic        desc_ready;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[PaddrBits-1:2];
  assign seq_load = wr_en && (reg_idx == RegFirstSeq);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      pt_q     <= 7'(PtReset);
      ssrc_q   <= '0;
      fseq_q   <= '0;
      maxlen_q <= 16'(MaxLenReset);
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCodecMode:   mode_q   <= pwdata[0];
        RegPayloadType: pt_q     <= pwdata[6:0];
        RegSourceId:    ssrc_q   <= pwdata;
        RegFirstSeq:    fseq_q   <= pwdata[15:0];
        RegMaxLen:      maxlen_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      RegCodecMode:   prdata = {31'd0, mode_q};
      RegPayloadType: prdata = {25'd0, pt_q};
      RegSourceId:    prdata = ssrc_q;
      RegFirstSeq:    prdata = {16'd0, fseq_q};
      RegMaxLen:      prdata = {16'd0, maxlen_q};
      default:        prdata = '0;
    endcase
  end

  // A first_sequence write passes its new value straight through, so the
  // running sequence number loads it at the same edge as the register.
  always_comb begin
    cfg.codec_mode     = mode_q;
    cfg.payload_type   = pt_q;
    cfg.source_id      = ssrc_q;
    cfg.first_sequence = seq_load ? pwdata[15:0] : fseq_q;
    cfg.max_packet_len = maxlen_q;
  end

  rnp_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .seq_load_i   (seq_load),
    .in_i         (in_i),
    .desc_o       (desc),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready)
  );

  rnp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .desc_i       (desc),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .out_o        (out_o)
  );

endmodule

FILE: hw/rtl/rnp_checker.sv
// Port-level assertions for the RTP packetizer and their bind.
`timescale 1ns / 1ps
module rnp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       packet_start_i,
  input logic       packet_end_i,
  input logic       run_last_i
);

  // A stalled output byte holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(packet_start_i) && $stable(packet_end_i) && $stable(run_last_i))
    else $error("output request changed while stalled");

  // A packet opens with the RTP version byte and is never closed by it.
  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_start_i |->
      out_byte_i == 8'h80 && !run_last_i && !packet_end_i)
    else $error("packet start is not a version byte");

  // The byte that closes a packet is the last one caused by its input byte.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_end_i |-> run_last_i)
    else $error("packet end before the end of its burst");

  // Once reset has been seen at an edge, no output follows at the next one.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind rtp_nal_fragment_packetizer rnp_checker u_rnp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .packet_start_i (out_o.packet_start),
  .packet_end_i   (out_o.packet_end),
  .run_last_i     (out_o.run_last)
);
